>>> rtl/core/dmarm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmarm_pkg
// Shared constants, codes and controller/datapath link types for the DMA
// descriptor ring manager.
// ----------------------------------------------------------------------------
package dmarm_pkg;

    localparam int unsigned RING_DEPTH_DEF = 16;
    localparam int unsigned MAX_COUNT      = 1023;
    localparam int unsigned ADDR_W         = 32;
    localparam int unsigned COUNT_W        = 10;
    localparam int unsigned SIZE_W         = 5;
    localparam int unsigned BYTES_W        = 13;
    localparam int unsigned NEXT_W         = 4;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 8;

    localparam logic [2:0] REQ_APPEND   = 3'd0;
    localparam logic [2:0] REQ_ENABLE   = 3'd1;
    localparam logic [2:0] REQ_COMPLETE = 3'd2;
    localparam logic [2:0] REQ_DISABLE  = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;

    localparam logic [1:0] CST_OK  = 2'd0;
    localparam logic [1:0] CST_RUN = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_INC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_INC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 3'd3;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_READY = 3'd1,
        PH_BUSY  = 3'd2,
        PH_DONE  = 3'd3,
        PH_ERROR = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LINK,
        ST_WRED,
        ST_QRED,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic link;
        logic mod_step;
        logic mod_swap;
        logic locate;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic need_link;
        logic need_locate;
        logic mod_ge;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  src_end;
        logic [ADDR_W-1:0]  dst_end;
        logic [COUNT_W-1:0] count;
    } desc_data_t;

endpackage

>>> rtl/core/dma_descriptor_ring_manager_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_descriptor_ring_manager_unit
// DMA descriptor ring with a five-phase channel controller, top level.
// ----------------------------------------------------------------------------
// Each request beat produces exactly one result beat. Requests are handled one
// at a time. Enable, disable, clear, rejected requests, completions that do
// not restart a slot, and appends to an empty queue pass from execute straight
// to the output state. An append onto a queued descriptor also passes through
// the link state, the second write to the link memory that chains the previous
// slot. A completion that restarts a queued slot passes through execute, the
// write-index and queue-depth reduction states and output; the reduction states
// repeat for each subtract step the slot reduction unit needs to bring the write
// index and queue depth below the active ring size (there are none unless
// ring_size was lowered with entries queued). A finished beat held back by the
// result channel holds the controller in its output state. The next request
// beat is taken while a finished result beat waits in the output register.
// Descriptor slots hold no value until an append writes them. Configuration
// writes are always accepted and must only be issued while the block is idle.
module dma_descriptor_ring_manager_unit
    import dmarm_pkg::*;
#(
    parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_req_type,
    input  logic [ADDR_W-1:0]     s_src_addr,
    input  logic [ADDR_W-1:0]     s_dst_addr,
    input  logic [BYTES_W-1:0]    s_byte_size,
    input  logic [1:0]            s_complete_status,
    input  logic                  s_slot_free,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_start_valid,
    output logic [ADDR_W-1:0]     m_desc_source,
    output logic [ADDR_W-1:0]     m_desc_dest,
    output logic [COUNT_W-1:0]    m_desc_count,
    output logic                  m_desc_reload,
    output logic [NEXT_W-1:0]     m_desc_next_index,
    output logic                  m_notify,
    output logic                  m_release_channel,
    output logic [2:0]            m_channel_state,
    output logic [SIZE_W-1:0]     m_queued_count,
    output logic                  m_rejected
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    dmarm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dmarm_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_req_type        (s_req_type),
        .s_src_addr        (s_src_addr),
        .s_dst_addr        (s_dst_addr),
        .s_byte_size       (s_byte_size),
        .s_complete_status (s_complete_status),
        .s_slot_free       (s_slot_free),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_start_valid     (m_start_valid),
        .m_desc_source     (m_desc_source),
        .m_desc_dest       (m_desc_dest),
        .m_desc_count      (m_desc_count),
        .m_desc_reload     (m_desc_reload),
        .m_desc_next_index (m_desc_next_index),
        .m_notify          (m_notify),
        .m_release_channel (m_release_channel),
        .m_channel_state   (m_channel_state),
        .m_queued_count    (m_queued_count),
        .m_rejected        (m_rejected)
    );

`ifndef SYNTHESIS
    // one request in flight: no beat taken the cycle after a beat is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request beat taken while previous one still in execution");

    a_idle_no_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_channel_state == PH_IDLE) |-> (m_queued_count == '0))
        else $error("queue depth reported while channel idle");

    a_no_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_start_valid |-> (m_desc_source == '0) && (m_desc_dest == '0)
            && (m_desc_count == '0) && !m_desc_reload && (m_desc_next_index == '0))
        else $error("descriptor fields set without a start");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_start_valid |-> !m_rejected && (m_channel_state == PH_BUSY))
        else $error("descriptor started outside busy phase");
`endif

endmodule

>>> rtl/core/dmarm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmarm_ctrl
// Sequencer for the descriptor ring manager: takes a request beat, steps the
// datapath through execute, link, slot reduction and result hand-off.
// ----------------------------------------------------------------------------
module dmarm_ctrl
    import dmarm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.need_link) begin
                    state_next = ST_LINK;
                end else if (stat.need_locate) begin
                    state_next = ST_WRED;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_LINK: begin
                state_next = ST_OUT;
            end
            ST_WRED: begin
                if (!stat.mod_ge) begin
                    state_next = ST_QRED;
                end
            end
            ST_QRED: begin
                if (!stat.mod_ge) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    state_next = s_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_LINK: begin
                cmd.link = 1'b1;
            end
            ST_WRED: begin
                cmd.mod_step = stat.mod_ge;
                cmd.mod_swap = !stat.mod_ge;
            end
            ST_QRED: begin
                cmd.mod_step = stat.mod_ge;
                cmd.locate   = !stat.mod_ge;
            end
            ST_OUT: begin
                s_ready      = stat.out_free;
                cmd.out_load = stat.out_free;
                cmd.latch    = stat.out_free && s_valid;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/core/dmarm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmarm_datapath
// Descriptor ring storage, channel phase and queue registers, request
// evaluation, slot reduction unit and the result output register.
// ----------------------------------------------------------------------------
module dmarm_datapath
    import dmarm_pkg::*;
#(
    parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [2:0]            s_req_type,
    input  logic [ADDR_W-1:0]     s_src_addr,
    input  logic [ADDR_W-1:0]     s_dst_addr,
    input  logic [BYTES_W-1:0]    s_byte_size,
    input  logic [1:0]            s_complete_status,
    input  logic                  s_slot_free,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_start_valid,
    output logic [ADDR_W-1:0]     m_desc_source,
    output logic [ADDR_W-1:0]     m_desc_dest,
    output logic [COUNT_W-1:0]    m_desc_count,
    output logic                  m_desc_reload,
    output logic [NEXT_W-1:0]     m_desc_next_index,
    output logic                  m_notify,
    output logic                  m_release_channel,
    output logic [2:0]            m_channel_state,
    output logic [SIZE_W-1:0]     m_queued_count,
    output logic                  m_rejected
);

    localparam int unsigned IW = $clog2(RING_DEPTH);

    // configuration
    logic [1:0]        width_code_reg;
    logic [1:0]        src_inc_reg;
    logic [1:0]        dst_inc_reg;
    logic [SIZE_W-1:0] ring_size_reg;

    // latched request beat
    logic [2:0]         req_reg;
    logic [ADDR_W-1:0]  src_reg;
    logic [ADDR_W-1:0]  dst_reg;
    logic [BYTES_W-1:0] size_reg;
    logic [1:0]         status_reg;
    logic               free_reg;

    // channel state
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [SIZE_W-1:0] pending_reg;
    logic [SIZE_W-1:0] pending_next;
    logic [SIZE_W-1:0] wi_reg;
    logic [SIZE_W-1:0] wi_next;

    // per-request results
    logic start_reg, start_next;
    logic notify_reg, notify_next;
    logic release_reg, release_next;
    logic rej_reg, rej_next;
    logic app_we;
    logic link_need;
    logic locate_need;

    logic [SIZE_W-1:0] prev_reg;
    logic [SIZE_W-1:0] idx_reg;
    logic [SIZE_W-1:0] mod_reg;
    logic [SIZE_W-1:0] wm_reg;

    // ring storage
    desc_data_t data_mem [RING_DEPTH];
    logic [IW:0] link_mem [RING_DEPTH];
    desc_data_t  rd_data_reg;
    logic [IW:0] rd_link_reg;

    logic        rd_en;
    logic [IW-1:0] rd_addr;
    logic        link_we;
    logic [IW-1:0] link_waddr;
    logic [IW:0] link_wdata;

    // append evaluation
    logic [SIZE_W-1:0]  cap;
    logic [1:0]         w_eff;
    logic [1:0]         lo_mask;
    logic               addr_zero;
    logic               align_bad;
    logic [BYTES_W-1:0] elems;
    logic [BYTES_W-1:0] cnt_full;
    logic               cnt_bad;
    logic               done_err;
    logic [SIZE_W-1:0]  app_q;
    logic [SIZE_W-1:0]  app_wi;
    logic [SIZE_W-1:0]  app_idx;
    logic [SIZE_W-1:0]  app_prev;
    logic [SIZE_W:0]    idx_inc;
    logic [SIZE_W-1:0]  app_wi_nxt;
    logic [ADDR_W-1:0]  span;
    logic [ADDR_W-1:0]  src_end;
    logic [ADDR_W-1:0]  dst_end;
    logic               app_ok;
    logic [SIZE_W-1:0]  cmp_pend;
    logic [SIZE_W:0]    loc_sum;
    logic [SIZE_W:0]    loc_slot;

    // output register
    logic m_valid_reg;

    function automatic logic [ADDR_W-1:0] stride_off(input logic [ADDR_W-1:0] sp,
                                                     input logic [1:0] code);
        logic [ADDR_W-1:0] off;
        case (code)
            2'd0:    off = '0;
            2'd1:    off = sp;
            2'd2:    off = sp << 1;
            default: off = sp << 2;
        endcase
        return off;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_code_reg <= 2'd0;
            src_inc_reg    <= 2'd1;
            dst_inc_reg    <= 2'd1;
            ring_size_reg  <= SIZE_W'(16);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WIDTH:     width_code_reg <= cfg_data[1:0];
                CFG_SRC_INC:   src_inc_reg    <= cfg_data[1:0];
                CFG_DST_INC:   dst_inc_reg    <= cfg_data[1:0];
                CFG_RING_SIZE: ring_size_reg  <= cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            req_reg    <= s_req_type;
            src_reg    <= s_src_addr;
            dst_reg    <= s_dst_addr;
            size_reg   <= s_byte_size;
            status_reg <= s_complete_status;
            free_reg   <= s_slot_free;
        end
    end

    always_comb begin
        if (ring_size_reg == '0) begin
            cap = SIZE_W'(1);
        end else if (32'(ring_size_reg) > RING_DEPTH) begin
            cap = SIZE_W'(RING_DEPTH);
        end else begin
            cap = ring_size_reg;
        end
    end

    assign w_eff     = (width_code_reg == 2'd3) ? 2'd2 : width_code_reg;
    assign lo_mask   = 2'((3'd1 << w_eff) - 3'd1);
    assign addr_zero = (src_reg == '0) || (dst_reg == '0);
    assign align_bad = (|(src_reg[1:0] & lo_mask)) || (|(dst_reg[1:0] & lo_mask))
                    || (|(size_reg[1:0] & lo_mask));
    assign elems     = size_reg >> w_eff;
    assign cnt_full  = elems - BYTES_W'(1);
    assign cnt_bad   = (elems == '0) || (32'(cnt_full) > MAX_COUNT);
    assign done_err  = (phase_reg == PH_DONE) || (phase_reg == PH_ERROR);
    assign app_q     = done_err ? '0 : pending_reg;
    assign app_wi    = done_err ? '0 : wi_reg;
    assign app_idx   = (app_wi < cap) ? app_wi : '0;
    assign app_prev  = (app_idx != '0) ? app_idx - SIZE_W'(1) : cap - SIZE_W'(1);
    assign idx_inc   = {1'b0, app_idx} + (SIZE_W+1)'(1);
    assign app_wi_nxt = (idx_inc >= {1'b0, cap}) ? '0 : idx_inc[SIZE_W-1:0];
    assign span      = ADDR_W'(cnt_full[COUNT_W-1:0]) << w_eff;
    assign src_end   = src_reg + stride_off(span, src_inc_reg);
    assign dst_end   = dst_reg + stride_off(span, dst_inc_reg);
    assign app_ok    = !addr_zero && !align_bad && !cnt_bad && (app_q < cap);
    assign cmp_pend  = (pending_reg != '0) ? pending_reg - SIZE_W'(1) : '0;

    always_comb begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        wi_next      = wi_reg;
        start_next   = 1'b0;
        notify_next  = 1'b0;
        release_next = 1'b0;
        rej_next     = 1'b0;
        app_we       = 1'b0;
        link_need    = 1'b0;
        locate_need  = 1'b0;
        if (cmd.exec) begin
            case (req_reg)
                REQ_APPEND: begin
                    if (app_ok) begin
                        wi_next      = app_wi_nxt;
                        pending_next = app_q + SIZE_W'(1);
                        if (phase_reg != PH_BUSY) begin
                            phase_next = PH_READY;
                        end
                        app_we    = 1'b1;
                        link_need = (app_q != '0);
                    end else begin
                        rej_next = 1'b1;
                    end
                end
                REQ_ENABLE: begin
                    if (phase_reg != PH_READY) begin
                        rej_next = 1'b1;
                    end else if (!free_reg) begin
                        phase_next = PH_ERROR;
                        rej_next   = 1'b1;
                    end else begin
                        phase_next = PH_BUSY;
                        start_next = 1'b1;
                    end
                end
                REQ_COMPLETE: begin
                    if (phase_reg != PH_BUSY) begin
                        rej_next = 1'b1;
                    end else begin
                        pending_next = cmp_pend;
                        case (status_reg)
                            CST_OK: begin
                                if (cmp_pend != '0) begin
                                    locate_need = 1'b1;
                                    start_next  = 1'b1;
                                    notify_next = 1'b1;
                                end else begin
                                    phase_next = PH_DONE;
                                end
                            end
                            CST_RUN: begin
                                notify_next = 1'b1;
                            end
                            default: begin
                                phase_next = PH_ERROR;
                            end
                        endcase
                        if (phase_next != PH_BUSY) begin
                            release_next = 1'b1;
                            notify_next  = 1'b1;
                        end
                    end
                end
                REQ_DISABLE: begin
                    if (phase_reg == PH_BUSY) begin
                        release_next = 1'b1;
                        phase_next   = PH_DONE;
                    end
                end
                REQ_CLEAR: begin
                    wi_next      = '0;
                    pending_next = '0;
                    phase_next   = PH_IDLE;
                end
                default: begin
                    rej_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            pending_reg <= '0;
            wi_reg      <= '0;
        end else begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
            wi_reg      <= wi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            start_reg   <= start_next;
            notify_reg  <= notify_next;
            release_reg <= release_next;
            rej_reg     <= rej_next;
            prev_reg    <= app_prev;
            idx_reg     <= app_idx;
        end
    end

    // slot reduction: write index and queue depth modulo ring size
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            mod_reg <= wi_reg;
        end else if (cmd.mod_step) begin
            mod_reg <= mod_reg - cap;
        end else if (cmd.mod_swap) begin
            wm_reg  <= mod_reg;
            mod_reg <= pending_reg;
        end
    end

    assign loc_sum  = {1'b0, wm_reg} + {1'b0, cap} - {1'b0, mod_reg};
    assign loc_slot = (loc_sum >= {1'b0, cap}) ? loc_sum - {1'b0, cap} : loc_sum;

    // ring memories
    assign rd_en      = cmd.exec || cmd.locate;
    assign rd_addr    = cmd.locate ? IW'(loc_slot[SIZE_W-1:0]) : '0;
    assign link_we    = app_we || cmd.link;
    assign link_waddr = cmd.link ? IW'(prev_reg) : IW'(app_idx);
    assign link_wdata = cmd.link ? {1'b1, IW'(idx_reg)} : '0;

    always_ff @(posedge aclk) begin
        if (app_we) begin
            data_mem[IW'(app_idx)] <= '{src_end: src_end, dst_end: dst_end,
                                        count: cnt_full[COUNT_W-1:0]};
        end
        if (rd_en) begin
            rd_data_reg <= data_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (rd_en) begin
            rd_link_reg <= link_mem[rd_addr];
        end
    end

    // result output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_start_valid     <= start_reg;
            m_desc_source     <= start_reg ? rd_data_reg.src_end : '0;
            m_desc_dest       <= start_reg ? rd_data_reg.dst_end : '0;
            m_desc_count      <= start_reg ? rd_data_reg.count : '0;
            m_desc_reload     <= start_reg && rd_link_reg[IW];
            m_desc_next_index <= (start_reg && rd_link_reg[IW])
                                 ? NEXT_W'(rd_link_reg[IW-1:0]) : '0;
            m_notify          <= notify_reg;
            m_release_channel <= release_reg;
            m_channel_state   <= phase_reg;
            m_queued_count    <= (phase_reg == PH_IDLE) ? '0 : pending_reg;
            m_rejected        <= rej_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign stat.need_link   = link_need;
    assign stat.need_locate = locate_need;
    assign stat.mod_ge      = (mod_reg >= cap);
    assign stat.out_free    = !m_valid_reg || m_ready;

endmodule
